FILE: design/rbsi_pkg.sv
// Shared types and constants for the ray/box slab intersection unit.
// No dependencies.
package rbsi_pkg;

  localparam int QW = 32;          // Q16.16 word
  localparam int HW = 31;          // half extent width
  localparam int NW = 49;          // dividend magnitude bits = quotient bits
  localparam int RW = 32;          // remainder / divisor width
  localparam int TW = 51;          // signed distance width inside the pipe
  localparam int AXES = 3;
  localparam int LAT = NW + 4;     // accept edge to strobe sample edge

  localparam logic signed [TW-1:0] FAR_POS = TW'((64'sd1 <<< (TW - 1)) - 64'sd1);
  localparam logic signed [TW-1:0] FAR_NEG = -FAR_POS;
  localparam logic signed [TW-1:0] Q_MAX_T = TW'(64'sd2147483647);
  localparam logic signed [TW-1:0] Q_MIN_T = TW'(-64'sd2147483648);

  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_CENTER_Z = 3'd2;
  localparam logic [2:0] REG_HALF_X   = 3'd3;
  localparam logic [2:0] REG_HALF_Y   = 3'd4;
  localparam logic [2:0] REG_HALF_Z   = 3'd5;

  // One axis in flight: both face divisions share the divisor.
  typedef struct packed {
    logic [NW-1:0] num_a;
    logic [NW-1:0] num_b;
    logic [NW-1:0] q_a;
    logic [NW-1:0] q_b;
    logic [RW-1:0] rem_a;
    logic [RW-1:0] rem_b;
    logic [RW-1:0] div;
    logic          neg_a;
    logic          neg_b;
    logic          par;
    logic          outside;
    logic          valid;
  } cell_t;

endpackage

FILE: design/rbsi_div_cell.sv
// One restoring-division step for both faces of an axis, registered.
// Depends on rbsi_pkg.
module rbsi_div_cell import rbsi_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cell_t din,
  output cell_t dout
);

  cell_t dnext;
  logic [RW:0] sh_a, sh_b, dv;
  logic ge_a, ge_b;

  always_comb begin
    dnext = din;
    dv    = {1'b0, din.div};
    sh_a  = {din.rem_a, din.num_a[NW-1]};
    sh_b  = {din.rem_b, din.num_b[NW-1]};
    ge_a  = sh_a >= dv;
    ge_b  = sh_b >= dv;
    dnext.rem_a = ge_a ? RW'(sh_a - dv) : RW'(sh_a);
    dnext.rem_b = ge_b ? RW'(sh_b - dv) : RW'(sh_b);
    dnext.q_a   = {din.q_a[NW-2:0], ge_a};
    dnext.q_b   = {din.q_b[NW-2:0], ge_b};
    dnext.num_a = {din.num_a[NW-2:0], 1'b0};
    dnext.num_b = {din.num_b[NW-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) dout <= '0;
    else     dout <= dnext;
  end

endmodule

FILE: design/rbsi_axis_chain.sv
// Row of NW division cells for one axis; one quotient bit per cell.
// Depends on rbsi_pkg and rbsi_div_cell.
module rbsi_axis_chain import rbsi_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cell_t head,
  output cell_t tail
);

  cell_t stg [0:NW];

  assign stg[0] = head;

  for (genvar i = 0; i < NW; i++) begin : g_cell
    rbsi_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (stg[i]),
      .dout (stg[i+1])
    );
  end

  assign tail = stg[NW];

endmodule

FILE: design/ray_box_slab_intersect_unit.sv
// Ray versus axis-aligned box slab test, signed Q16.16, fully pipelined.
// From the start beat to the done strobe a ray passes 1 prep stage,
// 49 division cells and 3 combine stages. Throughput: one ray per cycle;
// busy is never raised since the receiver cannot stall and nothing backs up.
// Reset (rst, synchronous, active high) clears the box registers to zero
// and drops every in-flight beat.
module ray_box_slab_intersect_unit import rbsi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // ray command
  input  logic                 start,
  output logic                 busy,
  input  logic signed [QW-1:0] origin_x,
  input  logic signed [QW-1:0] origin_y,
  input  logic signed [QW-1:0] origin_z,
  input  logic signed [QW-1:0] dir_x,
  input  logic signed [QW-1:0] dir_y,
  input  logic signed [QW-1:0] dir_z,
  // result strobe
  output logic                 done,
  output logic                 hit,
  output logic signed [QW-1:0] distance,
  // configuration write
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [QW-1:0]        cfg_data
);

  // Box registers
  logic signed [QW-1:0] center [AXES];
  logic [HW-1:0]        half   [AXES];

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < AXES; a++) begin
        center[a] <= '0;
        half[a]   <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CENTER_X: center[0] <= cfg_data;
        REG_CENTER_Y: center[1] <= cfg_data;
        REG_CENTER_Z: center[2] <= cfg_data;
        REG_HALF_X:   half[0]   <= cfg_data[HW-1:0];
        REG_HALF_Y:   half[1]   <= cfg_data[HW-1:0];
        REG_HALF_Z:   half[2]   <= cfg_data[HW-1:0];
        default: ;
      endcase
    end
  end

  // Prep: faces, signed numerators turned into magnitude + sign, |dir|.
  // Numerator is (face - origin) << 16; the low 16 bits just feed zeros in.
  function automatic cell_t prep(input logic signed [QW-1:0] c,
                                 input logic [HW-1:0]        h,
                                 input logic signed [QW-1:0] o,
                                 input logic signed [QW-1:0] d,
                                 input logic                 v);
    logic signed [QW+1:0] lo, hi, os, na, nb, hs;
    logic [QW+1:0] ma, mb;
    cell_t r;
    hs = (QW+2)'(signed'({1'b0, h}));
    lo = (QW+2)'(c) - hs;
    hi = (QW+2)'(c) + hs;
    os = (QW+2)'(o);
    na = lo - os;
    nb = hi - os;
    ma = na[QW+1] ? (QW+2)'(-na) : (QW+2)'(na);
    mb = nb[QW+1] ? (QW+2)'(-nb) : (QW+2)'(nb);
    r.num_a   = {ma[QW:0], 16'b0};
    r.num_b   = {mb[QW:0], 16'b0};
    r.q_a     = '0;
    r.q_b     = '0;
    r.rem_a   = '0;
    r.rem_b   = '0;
    r.div     = d[QW-1] ? RW'(-d) : RW'(d);
    r.neg_a   = na[QW+1] ^ d[QW-1];
    r.neg_b   = nb[QW+1] ^ d[QW-1];
    r.par     = (d == '0);
    r.outside = (os < lo) || (os > hi);
    r.valid   = v;
    return r;
  endfunction

  cell_t head [AXES];
  cell_t tail [AXES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < AXES; a++) head[a] <= '0;
    end else begin
      head[0] <= prep(center[0], half[0], origin_x, dir_x, start && !busy);
      head[1] <= prep(center[1], half[1], origin_y, dir_y, start && !busy);
      head[2] <= prep(center[2], half[2], origin_z, dir_z, start && !busy);
    end
  end

  for (genvar a = 0; a < AXES; a++) begin : g_axis
    rbsi_axis_chain u_chain (
      .clk  (clk),
      .rst  (rst),
      .head (head[a]),
      .tail (tail[a])
    );
  end

  // Stage A: signed quotients, near/far per axis; parallel axis sets no limit.
  logic signed [TW-1:0] near_t [AXES];
  logic signed [TW-1:0] far_t  [AXES];
  logic                 blk    [AXES];
  logic                 va;
  logic signed [TW-1:0] near_next [AXES];
  logic signed [TW-1:0] far_next  [AXES];
  logic signed [TW-1:0] qa, qb;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      qa = signed'({2'b00, tail[a].q_a});
      qb = signed'({2'b00, tail[a].q_b});
      if (tail[a].neg_a) qa = -qa;
      if (tail[a].neg_b) qb = -qb;
      if (tail[a].par) begin
        near_next[a] = FAR_NEG;
        far_next[a]  = FAR_POS;
      end else begin
        near_next[a] = (qa < qb) ? qa : qb;
        far_next[a]  = (qa < qb) ? qb : qa;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < AXES; a++) begin
      near_t[a] <= near_next[a];
      far_t[a]  <= far_next[a];
      blk[a]    <= tail[a].par && tail[a].outside;
    end
    if (rst) va <= 1'b0;
    else     va <= tail[0].valid;
  end

  // Stage B: entry = max of nears, exit = min of fars.
  logic signed [TW-1:0] entry, exit_t, e01, x01;
  logic                 in_box, vb;

  always_comb begin
    e01 = (near_t[0] > near_t[1]) ? near_t[0] : near_t[1];
    x01 = (far_t[0] < far_t[1]) ? far_t[0] : far_t[1];
  end

  always_ff @(posedge clk) begin
    entry  <= (e01 > near_t[2]) ? e01 : near_t[2];
    exit_t <= (x01 < far_t[2]) ? x01 : far_t[2];
    in_box <= !(blk[0] || blk[1] || blk[2]);
    if (rst) vb <= 1'b0;
    else     vb <= va;
  end

  // Stage C: hit decision and saturation to Q16.16.
  logic                 hit_next;
  logic signed [TW-1:0] pick;
  logic signed [QW-1:0] dist_next;

  always_comb begin
    hit_next = in_box && (exit_t >= 0) && (entry <= exit_t);
    pick     = hit_next ? entry : exit_t;
    if (pick > Q_MAX_T)      dist_next = QW'(Q_MAX_T);
    else if (pick < Q_MIN_T) dist_next = QW'(Q_MIN_T);
    else                     dist_next = pick[QW-1:0];
  end

  always_ff @(posedge clk) begin
    hit      <= hit_next;
    distance <= dist_next;
    if (rst) done <= 1'b0;
    else     done <= vb;
  end

endmodule

FILE: design/rbsi_checker.sv
// Port-level checks for ray_box_slab_intersect_unit, with its bind.
// Depends on rbsi_pkg.
module rbsi_checker import rbsi_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // Every accepted beat returns after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("result strobe missing after accepted beat");

  // No result without a matching earlier accepted beat.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result strobe without matching beat");

  // Reset flushes the pipe.
  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

endmodule

bind ray_box_slab_intersect_unit rbsi_checker u_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
